// ----- rtl/core/imdct_pkg.sv -----
// Shared constants, types and the sine table builder of the IMDCT windowing core.
package imdct_pkg;

  // Frame and sample geometry
  localparam int unsigned FRAME_SIZE  = 256;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned IDX_W       = $clog2(FRAME_SIZE);
  localparam int unsigned BANK_AW     = IDX_W + 1;
  localparam int unsigned PHASE_W     = $clog2(8 * FRAME_SIZE);

  // Quarter-wave sine table
  localparam int unsigned QW_LEN = 2 * FRAME_SIZE + 1;
  localparam int unsigned QW_AW  = $clog2(QW_LEN);
  localparam int unsigned QW_DEN = 4 * FRAME_SIZE;
  localparam int unsigned ROM_W  = 15;
  localparam int unsigned COS_W  = ROM_W + 1;

  // Datapath widths
  localparam int unsigned PROD_W      = SAMPLE_BITS + COS_W;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned SCALE_SHIFT = $clog2(FRAME_SIZE) - 1;
  localparam int unsigned SCALED_W    = ACC_W + 1 - SCALE_SHIFT;
  localparam int unsigned WPROD_W     = SCALED_W + COS_W;
  localparam int unsigned WIN_SHIFT   = 30;
  localparam int unsigned Y_W         = WPROD_W + 1 - WIN_SHIFT;
  localparam int unsigned SUM_W       = Y_W + 1;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] ROM_MAX = 64'd32767;

  typedef logic [ROM_W-1:0] qw_table_t [0:QW_LEN-1];

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_WIN,
    ST_DRAIN,
    ST_SCALE,
    ST_WMUL,
    ST_ROUND,
    ST_FINISH
  } imdct_state_e;

  // Request to the sine table: two phases in units of pi/(4M)
  typedef struct packed {
    logic               en;
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_b;
  } rom_req_t;

  // Builds the quarter wave sin(pi*i/(4M)) in Q1.15 from a Q30 polynomial.
  function automatic qw_table_t build_qw_table();
    qw_table_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    int unsigned i;
    for (i = 0; i < QW_LEN; i++) begin
      x  = (PI_Q30 * 64'(i) + 64'(QW_DEN / 2)) / QW_DEN;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      q  = (s + (64'd1 << 14)) >> 15;
      if (q > ROM_MAX) begin
        q = ROM_MAX;
      end
      tab[i] = q[ROM_W-1:0];
    end
    return tab;
  endfunction

endpackage

// ----- rtl/core/imdct_coef_if.sv -----
// Coefficient input channel: valid/ready handshake with one spectral coefficient.
interface imdct_coef_if;
  import imdct_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink (input valid, input coefficient, output ready);
endinterface

// ----- rtl/core/imdct_smp_if.sv -----
// Sample output channel: valid/ready handshake with one time sample and its frame marker.
interface imdct_smp_if;
  import imdct_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_last;

  modport source (output valid, output sample, output frame_last, input ready);
  modport sink (input valid, input sample, input frame_last, output ready);
endinterface

// ----- rtl/core/imdct_rom.sv -----
// Dual-port quarter-wave sine ROM with full-period address folding and registered read.
module imdct_rom (
  input  logic                                 clk_i,
  input  imdct_pkg::rom_req_t                  req_i,
  output logic signed [imdct_pkg::COS_W-1:0]   sin_a_o,
  output logic signed [imdct_pkg::COS_W-1:0]   sin_b_o
);
  import imdct_pkg::*;

  localparam qw_table_t QwTable = build_qw_table();
  localparam logic [QW_AW-1:0] QwHalf = QW_AW'(2 * FRAME_SIZE);

  logic [QW_AW-1:0] idx_a;
  logic [QW_AW-1:0] idx_b;
  logic [ROM_W-1:0] data_a_q;
  logic [ROM_W-1:0] data_b_q;
  logic             neg_a_q;
  logic             neg_b_q;

  // The second quadrant of each half mirrors the table.
  always_comb begin
    idx_a = QW_AW'(req_i.phase_a[PHASE_W-3:0]);
    idx_b = QW_AW'(req_i.phase_b[PHASE_W-3:0]);
    if (req_i.phase_a[PHASE_W-2]) begin
      idx_a = QwHalf - idx_a;
    end
    if (req_i.phase_b[PHASE_W-2]) begin
      idx_b = QwHalf - idx_b;
    end
  end

  // Registered table read; the second half of the period is negated afterwards.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      data_a_q <= QwTable[idx_a];
      data_b_q <= QwTable[idx_b];
      neg_a_q  <= req_i.phase_a[PHASE_W-1];
      neg_b_q  <= req_i.phase_b[PHASE_W-1];
    end
  end

  assign sin_a_o = neg_a_q ? -$signed({1'b0, data_a_q}) : $signed({1'b0, data_a_q});
  assign sin_b_o = neg_b_q ? -$signed({1'b0, data_b_q}) : $signed({1'b0, data_b_q});

endmodule

// ----- rtl/core/imdct_sine_window_overlap_add_core.sv -----
// After its coefficient transfer a result passes the MAC, WIN, DRAIN, SCALE, WMUL, ROUND and
// FINISH states into the output register; no new coefficient is taken until IDLE. The memory
// delivers one coefficient per cycle in MAC, shared by both MAC lanes of the dot products.
// Reset: asynchronous, active low; clears the sequencer, the item position and bank select.
// The memories are not swept: during the first frame after reset the reads of the previous
// bank and of the overlap store are forced to zero, and every later read hits written data.
module imdct_sine_window_overlap_add_core (
  input logic         clk_i,
  input logic         rst_ni,
  imdct_coef_if.sink  coef_i,
  imdct_smp_if.source smp_o
);
  import imdct_pkg::*;

  localparam logic [IDX_W-1:0]   LastIdx   = IDX_W'(FRAME_SIZE - 1);
  localparam logic [PHASE_W-1:0] PhM       = PHASE_W'(FRAME_SIZE);
  localparam logic [PHASE_W-1:0] Ph2M      = PHASE_W'(2 * FRAME_SIZE);
  localparam logic [PHASE_W-1:0] Ph4M      = PHASE_W'(4 * FRAME_SIZE);
  localparam int unsigned        ScaleHalf = 1 << (SCALE_SHIFT - 1);
  localparam int unsigned        WinHalf   = 1 << (WIN_SHIFT - 1);

  // Sequencer and frame bookkeeping
  imdct_state_e     state_q, state_d;
  logic [IDX_W-1:0] item_idx_q;
  logic             bank_q;
  logic             first_q;
  logic [IDX_W-1:0] n_q;
  logic             rd_bank_q;
  logic             zero_q;
  logic [IDX_W-1:0] k_q;

  // Phase generators of the two cosine sequences
  logic [PHASE_W-1:0] arg_lo_q, arg_hi_q;
  logic [PHASE_W-1:0] step_lo_q, step_hi_q;
  logic [PHASE_W-1:0] base;
  logic [PHASE_W-1:0] win_lo;

  // Memories and their read registers
  logic [SAMPLE_BITS-1:0] coef_mem [0:2*FRAME_SIZE-1];
  logic [SAMPLE_BITS-1:0] ovl_mem [0:FRAME_SIZE-1];
  logic [SAMPLE_BITS-1:0] coef_rd_q;
  logic [SAMPLE_BITS-1:0] ovl_rd_q;

  // Datapath
  logic                          s1_v_q, s2_v_q;
  logic signed [SAMPLE_BITS-1:0] coef_op;
  logic signed [SAMPLE_BITS-1:0] ovl_op;
  logic signed [COS_W-1:0]       sin_a, sin_b;
  logic signed [PROD_W-1:0]      prod_lo_q, prod_hi_q;
  logic signed [ACC_W-1:0]       acc_lo_q, acc_hi_q;
  logic [ACC_W:0]                acc_lo_b, acc_hi_b;
  logic signed [SCALED_W-1:0]    scaled_lo_q, scaled_hi_q;
  logic signed [WPROD_W-1:0]     wprod_lo_q, wprod_hi_q;
  logic [WPROD_W:0]              wprod_lo_b, wprod_hi_b;
  logic signed [Y_W-1:0]         y_lo_q, y_hi_q;
  logic signed [SUM_W-1:0]       sum_lo;
  logic [SAMPLE_BITS-1:0]        sample_sat;
  logic [SAMPLE_BITS-1:0]        ovl_sat;

  // Handshake and control strobes
  logic     in_acc;
  logic     coef_ready;
  logic     mac_issue;
  logic     win_issue;
  logic     out_free;
  logic     fire;
  rom_req_t rom_req;

  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic                   out_last_q;

  // Clamps a sum to the signed sample range.
  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [SUM_W-1:0] v);
    logic sgn;
    logic ovf;
    sgn = v[SUM_W-1];
    ovf = (v[SUM_W-2:SAMPLE_BITS-1] != {(SUM_W - SAMPLE_BITS){sgn}});
    return ovf ? {sgn, {(SAMPLE_BITS - 1){~sgn}}} : v[SAMPLE_BITS-1:0];
  endfunction

  assign in_acc   = coef_i.valid & coef_ready;
  assign out_free = ~out_valid_q | smp_o.ready;

  // Phase of the first cosine term and of the window for this position.
  assign base   = PHASE_W'({item_idx_q, 1'b1}) + PhM;
  assign win_lo = PHASE_W'({n_q, 1'b1});

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (k_q == LastIdx) begin
          state_d = ST_WIN;
        end
      end
      ST_WIN:    state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_WMUL;
      ST_WMUL:   state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Output decoding of the sequencer
  always_comb begin
    coef_ready = 1'b0;
    mac_issue  = 1'b0;
    win_issue  = 1'b0;
    fire       = 1'b0;
    case (state_q)
      ST_IDLE:   coef_ready = 1'b1;
      ST_MAC:    mac_issue  = 1'b1;
      ST_WIN:    win_issue  = 1'b1;
      ST_FINISH: fire       = out_free;
      default: begin
        coef_ready = 1'b0;
      end
    endcase
    rom_req.en      = mac_issue | win_issue;
    rom_req.phase_a = mac_issue ? arg_lo_q : win_lo;
    rom_req.phase_b = mac_issue ? arg_hi_q : win_lo + Ph2M;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame position advances on each transfer; bank select and first-frame marker at frame end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_idx_q <= '0;
      bank_q     <= 1'b0;
      first_q    <= 1'b1;
      k_q        <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      s1_v_q <= mac_issue;
      s2_v_q <= s1_v_q;
      if (in_acc) begin
        k_q <= '0;
        if (item_idx_q == LastIdx) begin
          item_idx_q <= '0;
          bank_q     <= ~bank_q;
          first_q    <= 1'b0;
        end else begin
          item_idx_q <= item_idx_q + 1'b1;
        end
      end else if (mac_issue) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // Per-item context captured at the transfer, and the phase accumulators.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n_q       <= item_idx_q;
      rd_bank_q <= ~bank_q;
      zero_q    <= first_q;
      arg_lo_q  <= base + Ph2M;
      arg_hi_q  <= base + Ph4M;
      step_lo_q <= base << 1;
      step_hi_q <= (base << 1) + Ph4M;
    end else if (mac_issue) begin
      arg_lo_q <= arg_lo_q + step_lo_q;
      arg_hi_q <= arg_hi_q + step_hi_q;
    end
  end

  // Coefficient banks: the incoming frame is written while the previous one is read.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      coef_mem[{bank_q, item_idx_q}] <= coef_i.coefficient;
    end
    if (mac_issue) begin
      coef_rd_q <= coef_mem[{rd_bank_q, k_q}];
    end
  end

  // Overlap store: read at the transfer, written back when the result is issued.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ovl_rd_q <= ovl_mem[item_idx_q];
    end
    if (fire) begin
      ovl_mem[n_q] <= ovl_sat;
    end
  end

  imdct_rom u_rom (
    .clk_i   (clk_i),
    .req_i   (rom_req),
    .sin_a_o (sin_a),
    .sin_b_o (sin_b)
  );

  assign coef_op = zero_q ? '0 : $signed(coef_rd_q);
  assign ovl_op  = zero_q ? '0 : $signed(ovl_rd_q);

  // Two multiply-accumulate lanes share each coefficient read.
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      prod_lo_q <= coef_op * sin_a;
      prod_hi_q <= coef_op * sin_b;
    end
    if (in_acc) begin
      acc_lo_q <= '0;
      acc_hi_q <= '0;
    end else if (s2_v_q) begin
      acc_lo_q <= acc_lo_q + ACC_W'(prod_lo_q);
      acc_hi_q <= acc_hi_q + ACC_W'(prod_hi_q);
    end
  end

  // Rounding to nearest with halves away from zero: bias by half, less one when negative.
  assign acc_lo_b = {acc_lo_q[ACC_W-1], acc_lo_q} + (ACC_W + 1)'(ScaleHalf)
                  - (ACC_W + 1)'(acc_lo_q[ACC_W-1]);
  assign acc_hi_b = {acc_hi_q[ACC_W-1], acc_hi_q} + (ACC_W + 1)'(ScaleHalf)
                  - (ACC_W + 1)'(acc_hi_q[ACC_W-1]);
  assign wprod_lo_b = {wprod_lo_q[WPROD_W-1], wprod_lo_q} + (WPROD_W + 1)'(WinHalf)
                    - (WPROD_W + 1)'(wprod_lo_q[WPROD_W-1]);
  assign wprod_hi_b = {wprod_hi_q[WPROD_W-1], wprod_hi_q} + (WPROD_W + 1)'(WinHalf)
                    - (WPROD_W + 1)'(wprod_hi_q[WPROD_W-1]);

  // Scale by 2/M, apply the window, and bring the product back to sample scale.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCALE) begin
      scaled_lo_q <= $signed(acc_lo_b[ACC_W:SCALE_SHIFT]);
      scaled_hi_q <= $signed(acc_hi_b[ACC_W:SCALE_SHIFT]);
    end
    if (state_q == ST_WMUL) begin
      wprod_lo_q <= scaled_lo_q * sin_a;
      wprod_hi_q <= scaled_hi_q * sin_b;
    end
    if (state_q == ST_ROUND) begin
      y_lo_q <= $signed(wprod_lo_b[WPROD_W:WIN_SHIFT]);
      y_hi_q <= $signed(wprod_hi_b[WPROD_W:WIN_SHIFT]);
    end
  end

  // Overlap-add of the first half and saturation of both halves.
  assign sum_lo     = SUM_W'(y_lo_q) + SUM_W'(ovl_op);
  assign sample_sat = sat_sample(sum_lo);
  assign ovl_sat    = sat_sample(SUM_W'(y_hi_q));

  // Output register: holds a finished sample until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (smp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_sample_q <= sample_sat;
      out_last_q   <= (n_q == LastIdx);
    end
  end

  assign coef_i.ready     = coef_ready;
  assign smp_o.valid      = out_valid_q;
  assign smp_o.sample     = out_sample_q;
  assign smp_o.frame_last = out_last_q;

endmodule

// ----- rtl/core/imdct_checker.sv -----
// Port-level checks of the IMDCT windowing core, attached to the top level by a bind.
module imdct_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [imdct_pkg::SAMPLE_BITS-1:0]  sample_i,
  input logic                               frame_last_i
);
  import imdct_pkg::*;

  logic             in_xfer;
  logic             out_xfer;
  logic [2:0]       pend_q;
  logic [IDX_W-1:0] out_cnt_q;

  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;

  // Items transferred in but not yet delivered, and the position of the next result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      out_cnt_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_xfer) - 3'(out_xfer);
      if (out_xfer) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end
    end
  end

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_i) && $stable(frame_last_i))
    else $error("result payload changed while stalled");

  // An item occupies the datapath, so no transfer follows directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input taken again straight after a transfer");

  // At most one item in work and one result waiting; no result without an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= 3'd2) && (!out_valid_i || pend_q != 3'd0))
    else $error("results and transferred items out of step");

  // The frame marker sits on every FRAME_SIZE-th result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_last_i == (out_cnt_q == IDX_W'(FRAME_SIZE - 1)))
    else $error("frame marker on the wrong sample");

endmodule

bind imdct_sine_window_overlap_add_core imdct_checker u_imdct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (coef_i.valid),
  .in_ready_i   (coef_i.ready),
  .out_valid_i  (smp_o.valid),
  .out_ready_i  (smp_o.ready),
  .sample_i     (smp_o.sample),
  .frame_last_i (smp_o.frame_last)
);
